### rtl/brle8_pkg.sv
// Shared types and constants for the BMP RLE8 encoder.
// Used by the interfaces, the controller, the datapath and the top level.
package brle8_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned OUT_W       = 64;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned COL_W       = 13;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned MAX_WIDTH_D = 4096;
  localparam int unsigned MAX_RUN_D   = 255;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_LEN,
    SRC_LIT,
    SRC_VAL,
    SRC_EOL
  } src_e;

  typedef enum logic [1:0] {
    LEN_DIFF,
    LEN_REP,
    LEN_ONE,
    LEN_TWO
  } len_sel_e;

  typedef struct packed {
    logic     push;
    logic     step_start;
    logic     fetch;
    logic     shift;
    logic     set_len;
    len_sel_e len_sel;
    logic     rd_lit;
    logic     k_inc;
    logic     put;
    src_e     src;
    logic     commit;
    logic     row_end;
    logic     flush;
  } cmd_t;

  typedef struct packed {
    logic       restart;
    logic       w_one;
    logic       w_two;
    logic [1:0] lc;
    logic       inflight;
    logic       exhausted;
    logic       diff_cont;
    logic       rep_cont;
    logic       differs;
    logic       rep_ne;
    logic       cur_zero;
    logic       len_fits;
    logic       len_gt2;
    logic       len_odd;
    logic       k_last;
    logic       rowend_hit;
    logic       put_ok;
    logic       flush_ok;
  } sts_t;

endpackage

### rtl/brle8_if.sv
// Valid/ready channel interfaces for pixels in and packed code bytes out.
// Depends on brle8_pkg for the field widths.
interface brle8_pix_if;
  logic                          valid;
  logic                          ready;
  logic [brle8_pkg::PIX_W-1:0]   pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface brle8_out_if;
  logic                          valid;
  logic                          ready;
  logic [brle8_pkg::OUT_W-1:0]   out_bytes;
  logic [brle8_pkg::CNT_W-1:0]   byte_count;
  logic                          last_of_run;
  logic                          image_done;
  modport source (output valid, output out_bytes, output byte_count,
                  output last_of_run, output image_done, input ready);
  modport sink   (input valid, input out_bytes, input byte_count,
                  input last_of_run, input image_done, output ready);
endinterface

### rtl/brle8_datapath.sv
// Datapath: literal memory, scan window, counters, byte packer, output register.
// Depends on brle8_pkg; driven by brle8_ctrl through cmd_t, reports through sts_t.
module brle8_datapath #(
  parameter int unsigned MAX_WIDTH = brle8_pkg::MAX_WIDTH_D,
  parameter int unsigned MAX_RUN   = brle8_pkg::MAX_RUN_D
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brle8_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brle8_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [brle8_pkg::PIX_W-1:0]       pix_i,
  input  brle8_pkg::cmd_t                   cmd_i,
  output brle8_pkg::sts_t                   sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [brle8_pkg::OUT_W-1:0]       out_bytes_o,
  output logic [brle8_pkg::CNT_W-1:0]       byte_count_o,
  output logic                              last_of_run_o,
  output logic                              image_done_o
);

  localparam int unsigned AW    = $clog2(MAX_RUN + 2);
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned NW    = $clog2(MAX_RUN + 3);
  localparam int unsigned EW    = NW + 1;
  localparam int unsigned RW    = $clog2(MAX_RUN + 1);
  localparam int unsigned LW    = RW + 1;
  localparam int unsigned SW    = brle8_pkg::COL_W + 1;
  localparam int unsigned CW    = brle8_pkg::COL_W;
  localparam int unsigned PW    = brle8_pkg::PIX_W;
  localparam int unsigned OW    = brle8_pkg::OUT_W;
  localparam int unsigned KW    = brle8_pkg::CNT_W;

  logic [PW-1:0]      mem [DEPTH];
  logic [PW-1:0]      rd_q;
  logic [PW-1:0]      win_q [3];
  logic [CW-1:0]      width_q;
  logic [brle8_pkg::ROW_W-1:0] height_q;
  logic [brle8_pkg::ROW_W-1:0] row_q;
  logic [AW-1:0]      head_q;
  logic [NW-1:0]      n_q;
  logic [CW-1:0]      s_q;
  logic [RW-1:0]      cur_q;
  logic [1:0]         lc_q;
  logic               inflight_q;
  logic [RW-1:0]      tlen_q;
  logic [RW-1:0]      k_q;
  logic               done_q;
  logic [OW-1:0]      acc_q;
  logic [KW-1:0]      cnt_q;
  logic               ov_q;
  logic [OW-1:0]      ob_q;
  logic [KW-1:0]      oc_q;
  logic               ol_q;
  logic               od_q;

  logic [CW-1:0]      w_eff;
  logic [SW-1:0]      s_c2;
  logic               rowend_d;
  logic [LW-1:0]      len_diff;
  logic [RW-1:0]      len_new;
  logic               last_row;
  logic               push_en;
  logic               out_free;
  logic [AW-1:0]      rd_addr;
  logic [PW-1:0]      byte_v;

  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
  end

  assign s_c2     = SW'(s_q) + SW'(cur_q) + SW'(2);
  assign rowend_d = (s_c2 == SW'(w_eff)) && (32'(cur_q) != MAX_RUN);

  always_comb begin
    if (rowend_d) begin
      if (32'(cur_q) == MAX_RUN - 1) begin
        len_diff = LW'(MAX_RUN);
      end else begin
        len_diff = LW'(cur_q) + LW'(2);
      end
    end else begin
      len_diff = LW'(cur_q);
    end
  end

  always_comb begin
    case (cmd_i.len_sel)
      brle8_pkg::LEN_DIFF: len_new = RW'(len_diff);
      brle8_pkg::LEN_REP:  len_new = cur_q + RW'(1);
      brle8_pkg::LEN_ONE:  len_new = RW'(1);
      brle8_pkg::LEN_TWO:  len_new = RW'(2);
      default:             len_new = RW'(1);
    endcase
  end

  assign last_row = (height_q == '0) || (32'(row_q) + 1 >= 32'(height_q));
  assign push_en  = cmd_i.push && (32'(n_q) < MAX_RUN + 2);
  assign out_free = !ov_q || out_ready_i;
  assign rd_addr  = cmd_i.fetch ? head_q + AW'(cur_q) + AW'(lc_q) : head_q + AW'(k_q);

  always_comb begin
    case (cmd_i.src)
      brle8_pkg::SRC_ZERO: byte_v = '0;
      brle8_pkg::SRC_ONE:  byte_v = PW'(1);
      brle8_pkg::SRC_LEN:  byte_v = PW'(tlen_q);
      brle8_pkg::SRC_LIT:  byte_v = rd_q;
      brle8_pkg::SRC_VAL:  byte_v = win_q[0];
      brle8_pkg::SRC_EOL:  byte_v = last_row ? PW'(1) : '0;
      default:             byte_v = '0;
    endcase
  end

  always_comb begin
    sts_o            = '0;
    sts_o.restart    = cfg_we_i;
    sts_o.w_one      = (w_eff == CW'(1));
    sts_o.w_two      = (w_eff == CW'(2));
    sts_o.lc         = lc_q;
    sts_o.inflight   = inflight_q;
    sts_o.exhausted  = (EW'(cur_q) + EW'(lc_q)) >= EW'(n_q);
    sts_o.diff_cont  = (32'(cur_q) < MAX_RUN) && (s_c2 < SW'(w_eff));
    sts_o.rep_cont   = (32'(cur_q) + 1 < MAX_RUN) &&
                       (SW'(s_q) + SW'(cur_q) + SW'(1) < SW'(w_eff));
    sts_o.differs    = (win_q[0] != win_q[2]) || (win_q[0] != win_q[1]);
    sts_o.rep_ne     = (win_q[0] != win_q[1]);
    sts_o.cur_zero   = (cur_q == '0);
    sts_o.len_fits   = 32'(len_diff) <= 32'(n_q);
    sts_o.len_gt2    = len_diff > LW'(2);
    sts_o.len_odd    = tlen_q[0];
    sts_o.k_last     = (32'(k_q) + 1 == 32'(tlen_q));
    sts_o.rowend_hit = (SW'(s_q) + SW'(tlen_q)) >= SW'(w_eff);
    sts_o.put_ok     = (cnt_q != KW'(8)) || out_free;
    sts_o.flush_ok   = (cnt_q == '0) || out_free;
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[head_q + AW'(n_q)] <= pix_i;
    end
    if (cmd_i.fetch || cmd_i.rd_lit) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (inflight_q) begin
      win_q[lc_q] <= rd_q;
    end else if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
    end
    if (cmd_i.set_len) begin
      tlen_q <= len_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= CW'(1);
      height_q   <= 16'd1;
      row_q      <= '0;
      head_q     <= '0;
      n_q        <= '0;
      s_q        <= '0;
      cur_q      <= '0;
      lc_q       <= '0;
      inflight_q <= 1'b0;
      k_q        <= '0;
      done_q     <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == brle8_pkg::CFG_WIDTH) begin
        width_q <= cfg_data_i[CW-1:0];
      end else begin
        height_q <= cfg_data_i;
      end
      row_q      <= '0;
      n_q        <= '0;
      s_q        <= '0;
      cur_q      <= '0;
      lc_q       <= '0;
      inflight_q <= 1'b0;
    end else begin
      inflight_q <= cmd_i.fetch;
      if (push_en) begin
        n_q <= n_q + NW'(1);
      end
      if (cmd_i.step_start) begin
        done_q <= 1'b0;
      end
      if (inflight_q) begin
        lc_q <= lc_q + 2'd1;
      end else if (cmd_i.shift) begin
        lc_q  <= lc_q - 2'd1;
        cur_q <= cur_q + RW'(1);
      end
      if (cmd_i.set_len) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + RW'(1);
      end
      if (cmd_i.commit) begin
        head_q <= head_q + AW'(tlen_q);
        cur_q  <= '0;
        lc_q   <= '0;
        if (sts_o.rowend_hit) begin
          s_q <= '0;
          n_q <= '0;
        end else begin
          s_q <= s_q + CW'(tlen_q);
          n_q <= n_q - NW'(tlen_q);
        end
      end
      if (cmd_i.row_end) begin
        if (last_row) begin
          row_q  <= '0;
          done_q <= 1'b1;
        end else begin
          row_q <= row_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (cmd_i.put) begin
        if (cnt_q == KW'(8)) begin
          acc_q <= OW'(byte_v);
          cnt_q <= KW'(1);
        end else begin
          acc_q <= acc_q | (OW'(byte_v) << {cnt_q[2:0], 3'b000});
          cnt_q <= cnt_q + KW'(1);
        end
      end else if (cmd_i.flush && (cnt_q != '0)) begin
        acc_q <= '0;
        cnt_q <= '0;
      end
      if ((cmd_i.put && (cnt_q == KW'(8))) || (cmd_i.flush && (cnt_q != '0))) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.put && (cnt_q == KW'(8))) || (cmd_i.flush && (cnt_q != '0))) begin
      ob_q <= acc_q;
      oc_q <= cnt_q;
      ol_q <= cmd_i.flush;
      od_q <= cmd_i.flush && done_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_bytes_o   = ob_q;
  assign byte_count_o  = oc_q;
  assign last_of_run_o = ol_q;
  assign image_done_o  = od_q;

endmodule

### rtl/brle8_ctrl.sv
// Controller: sequences scan, token decision, byte emission and flush.
// Depends on brle8_pkg; commands brle8_datapath through cmd_t.
module brle8_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  output logic              pix_ready_o,
  input  brle8_pkg::sts_t   sts_i,
  output brle8_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DEC,
    ST_REP,
    ST_ABS_Z,
    ST_ABS_N,
    ST_LIT_RD,
    ST_LIT_PUT,
    ST_PAD,
    ST_PAIR_ONE,
    ST_REP_N,
    ST_REP_V,
    ST_COMMIT,
    ST_EOL_Z,
    ST_EOL_V,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d, resume_q, resume_d;
  logic   pair_q, pair_d;
  logic   have;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    resume_d = resume_q;
    pair_d   = pair_q;
    have     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pix_valid_i) begin
          cmd_o.push       = 1'b1;
          cmd_o.step_start = 1'b1;
          state_d          = resume_q;
        end
      end
      ST_DIFF: begin
        if (!sts_i.inflight) begin
          if (sts_i.w_one || sts_i.w_two) begin
            have = sts_i.w_one ? (sts_i.lc != 2'd0) : (sts_i.lc >= 2'd2);
            if (have) begin
              cmd_o.set_len = 1'b1;
              cmd_o.len_sel = sts_i.w_one ? brle8_pkg::LEN_ONE : brle8_pkg::LEN_TWO;
              pair_d        = 1'b1;
              state_d       = ST_PAIR_ONE;
            end else if (sts_i.exhausted) begin
              resume_d = state_q;
              state_d  = ST_FLUSH;
            end else begin
              cmd_o.fetch = 1'b1;
            end
          end else if (!sts_i.diff_cont) begin
            state_d = ST_DEC;
          end else if (sts_i.lc != 2'd3) begin
            if (sts_i.exhausted) begin
              resume_d = state_q;
              state_d  = ST_FLUSH;
            end else begin
              cmd_o.fetch = 1'b1;
            end
          end else if (sts_i.differs) begin
            cmd_o.shift = 1'b1;
          end else begin
            state_d = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (sts_i.cur_zero) begin
          state_d = ST_REP;
        end else if (!sts_i.len_fits) begin
          resume_d = state_q;
          state_d  = ST_FLUSH;
        end else begin
          cmd_o.set_len = 1'b1;
          cmd_o.len_sel = brle8_pkg::LEN_DIFF;
          pair_d        = !sts_i.len_gt2;
          state_d       = sts_i.len_gt2 ? ST_ABS_Z : ST_PAIR_ONE;
        end
      end
      ST_REP: begin
        if (!sts_i.inflight) begin
          have = sts_i.rep_cont ? (sts_i.lc >= 2'd2) : (sts_i.lc != 2'd0);
          if (!have) begin
            if (sts_i.exhausted) begin
              resume_d = state_q;
              state_d  = ST_FLUSH;
            end else begin
              cmd_o.fetch = 1'b1;
            end
          end else if (!sts_i.rep_cont || sts_i.rep_ne) begin
            cmd_o.set_len = 1'b1;
            cmd_o.len_sel = brle8_pkg::LEN_REP;
            state_d       = ST_REP_N;
          end else begin
            cmd_o.shift = 1'b1;
          end
        end
      end
      ST_ABS_Z: begin
        cmd_o.src = brle8_pkg::SRC_ZERO;
        if (sts_i.put_ok) begin
          cmd_o.put = 1'b1;
          state_d   = ST_ABS_N;
        end
      end
      ST_ABS_N: begin
        cmd_o.src = brle8_pkg::SRC_LEN;
        if (sts_i.put_ok) begin
          cmd_o.put = 1'b1;
          state_d   = ST_LIT_RD;
        end
      end
      ST_LIT_RD: begin
        cmd_o.rd_lit = 1'b1;
        state_d      = ST_LIT_PUT;
      end
      ST_LIT_PUT: begin
        cmd_o.src = brle8_pkg::SRC_LIT;
        if (sts_i.put_ok) begin
          cmd_o.put   = 1'b1;
          cmd_o.k_inc = 1'b1;
          if (sts_i.k_last) begin
            state_d = (!pair_q && sts_i.len_odd) ? ST_PAD : ST_COMMIT;
          end else begin
            state_d = pair_q ? ST_PAIR_ONE : ST_LIT_RD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.src = brle8_pkg::SRC_ZERO;
        if (sts_i.put_ok) begin
          cmd_o.put = 1'b1;
          state_d   = ST_COMMIT;
        end
      end
      ST_PAIR_ONE: begin
        cmd_o.src = brle8_pkg::SRC_ONE;
        if (sts_i.put_ok) begin
          cmd_o.put = 1'b1;
          state_d   = ST_LIT_RD;
        end
      end
      ST_REP_N: begin
        cmd_o.src = brle8_pkg::SRC_LEN;
        if (sts_i.put_ok) begin
          cmd_o.put = 1'b1;
          state_d   = ST_REP_V;
        end
      end
      ST_REP_V: begin
        cmd_o.src = brle8_pkg::SRC_VAL;
        if (sts_i.put_ok) begin
          cmd_o.put = 1'b1;
          state_d   = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.rowend_hit ? ST_EOL_Z : ST_DIFF;
      end
      ST_EOL_Z: begin
        cmd_o.src = brle8_pkg::SRC_ZERO;
        if (sts_i.put_ok) begin
          cmd_o.put = 1'b1;
          state_d   = ST_EOL_V;
        end
      end
      ST_EOL_V: begin
        cmd_o.src = brle8_pkg::SRC_EOL;
        if (sts_i.put_ok) begin
          cmd_o.put     = 1'b1;
          cmd_o.row_end = 1'b1;
          state_d       = ST_DIFF;
        end
      end
      ST_FLUSH: begin
        if (sts_i.flush_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      resume_q <= ST_DIFF;
      pair_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      pair_q   <= pair_d;
      resume_q <= sts_i.restart ? ST_DIFF : resume_d;
    end
  end

  assign pix_ready_o = (state_q == ST_IDLE);

endmodule

### rtl/bmp_rle8_encoder.sv
// BMP RLE8 encoder top level; depends on brle8_pkg, brle8_if, brle8_ctrl and brle8_datapath.
// After each pixel transfer the input stays busy until its scan, tokens and flush are done.
// Each token adds scan and decision steps, its header or count bytes, a memory read then a pack
// for each literal byte, and a commit; each pixel ends with a flush, which output stalls hold.
// A result is valid the cycle after the put or flush that closes it; stalls hold it.
// Reset clears control state and sets width and height to 1; the literal memory is not cleared.
module bmp_rle8_encoder #(
  parameter int unsigned MAX_WIDTH = brle8_pkg::MAX_WIDTH_D,
  parameter int unsigned MAX_RUN   = brle8_pkg::MAX_RUN_D
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brle8_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brle8_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  brle8_pix_if.sink                         pixel_if,
  brle8_out_if.source                       code_if
);

  brle8_pkg::cmd_t cmd;
  brle8_pkg::sts_t sts;

  brle8_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pixel_if.valid),
    .pix_ready_o (pixel_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brle8_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RUN   (MAX_RUN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pix_i         (pixel_if.pixel),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (code_if.ready),
    .out_valid_o   (code_if.valid),
    .out_bytes_o   (code_if.out_bytes),
    .byte_count_o  (code_if.byte_count),
    .last_of_run_o (code_if.last_of_run),
    .image_done_o  (code_if.image_done)
  );

endmodule

### rtl/brle8_chk.sv
// Port-level checker for bmp_rle8_encoder, attached with a bind.
// Depends on brle8_pkg for field widths.
module brle8_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            pix_valid,
  input logic                            pix_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [brle8_pkg::CNT_W-1:0]     byte_count,
  input logic                            last_of_run,
  input logic                            image_done
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (byte_count != '0) && (byte_count <= 4'd8))
    else $error("byte count out of range");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && image_done |-> last_of_run)
    else $error("end marker not on last item of its pixel");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("pixel taken before previous one processed");

endmodule

bind bmp_rle8_encoder brle8_chk u_brle8_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid   (pixel_if.valid),
  .pix_ready   (pixel_if.ready),
  .out_valid   (code_if.valid),
  .out_ready   (code_if.ready),
  .byte_count  (code_if.byte_count),
  .last_of_run (code_if.last_of_run),
  .image_done  (code_if.image_done)
);

### bench/bmp_rle8_encoder_tb.sv
// Self-checking bench for bmp_rle8_encoder: drives pixels and register writes.
// A scoreboard predicts the packed RLE8 code items and checks each transfer.
// Depends on brle8_pkg, brle8_if and the encoder RTL.
module bmp_rle8_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [brle8_pkg::OUT_W-1:0] bytes;
    bit [brle8_pkg::CNT_W-1:0] count;
    bit                        last;
    bit                        done;
  } code_item_t;

  typedef enum int {
    PAT_ANY,
    PAT_FEW,
    PAT_FLAT,
    PAT_COUNT
  } pattern_e;

  class rle8_scoreboard;
    bit [7:0]    pend [brle8_pkg::MAX_RUN_D+2];
    int unsigned npend, col, row, width_reg, height_reg;
    bit [7:0]    code_bytes [$];
    bit          end_mark;
    code_item_t  expected [$];
    int          errors;

    function new();
      width_reg = 1;
      height_reg = 1;
      restart();
    endfunction

    function void restart();
      foreach (pend[k]) pend[k] = '0;
      npend = 0;
      col = 0;
      row = 0;
    endfunction

    function void configure(bit [brle8_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
      if (idx == brle8_pkg::CFG_WIDTH) width_reg = val & 'h1FFF;
      else height_reg = val & 'hFFFF;
      restart();
    endfunction

    function bit differs(int unsigned k);
      return pend[k] != pend[k+2] || pend[k] != pend[k+1];
    endfunction

    function void put(int unsigned b);
      code_bytes.push_back(b[7:0]);
    endfunction

    function bit take_token(int unsigned w);
      int unsigned s, n, len, d, r, h;
      s = col;
      n = npend;
      if (n == 0) return 0;
      if (w == 1) begin
        put(1); put(pend[0]);
        len = 1;
      end else if (w == 2) begin
        if (n < 2) return 0;
        put(1); put(pend[0]); put(1); put(pend[1]);
        len = 2;
      end else begin
        d = 0;
        while (d < brle8_pkg::MAX_RUN_D && s + d + 2 < w) begin
          if (d + 2 >= n) return 0;
          if (!differs(d)) break;
          d++;
        end
        if (d > 0) begin
          if (s + d + 2 == w && d != brle8_pkg::MAX_RUN_D)
            len = (d == brle8_pkg::MAX_RUN_D - 1) ? brle8_pkg::MAX_RUN_D : d + 2;
          else
            len = d;
          if (len > n) return 0;
          if (len > 2) begin
            put(0); put(len);
            for (int k = 0; k < len; k++) put(pend[k]);
            if (len & 1) put(0);
          end else if (len == 2) begin
            put(1); put(pend[0]); put(1); put(pend[1]);
          end else begin
            put(1); put(pend[0]);
          end
        end else begin
          r = 1;
          while (r < brle8_pkg::MAX_RUN_D && s + r < w) begin
            if (r >= n) return 0;
            if (pend[r-1] != pend[r]) break;
            r++;
          end
          put(r); put(pend[r-1]);
          len = r;
        end
      end
      for (int k = 0; k < n - len; k++) pend[k] = pend[k+len];
      npend = n - len;
      col = s + len;
      if (col >= w) begin
        h = (height_reg == 0) ? 1 : height_reg;
        col = 0;
        npend = 0;
        if (row + 1 >= h) begin
          put(0); put(1);
          end_mark = 1;
          row = 0;
        end else begin
          put(0); put(0);
          row++;
        end
      end
      return 1;
    endfunction

    function void note_pixel(bit [brle8_pkg::PIX_W-1:0] px);
      int unsigned w, items, cnt;
      code_item_t it;
      w = (width_reg < 1) ? 1 :
          (width_reg > brle8_pkg::MAX_WIDTH_D) ? brle8_pkg::MAX_WIDTH_D : width_reg;
      code_bytes.delete();
      end_mark = 0;
      if (npend < brle8_pkg::MAX_RUN_D + 2) begin
        pend[npend] = px;
        npend++;
      end
      while (take_token(w)) ;
      items = (code_bytes.size() + 7) / 8;
      for (int k = 0; k < items; k++) begin
        cnt = code_bytes.size() - k * 8;
        if (cnt > 8) cnt = 8;
        it.bytes = '0;
        for (int j = 0; j < cnt; j++) it.bytes[8*j +: 8] = code_bytes[k*8 + j];
        it.count = cnt[brle8_pkg::CNT_W-1:0];
        it.last = (k + 1 == items);
        it.done = end_mark && (k + 1 == items);
        expected.push_back(it);
      end
    endfunction

    function void check_code(code_item_t got);
      code_item_t exp_item;
      if (expected.size() == 0) begin
        $error("unexpected code item: out_bytes %h", got.bytes);
        errors++;
        return;
      end
      exp_item = expected.pop_front();
      if (got.bytes != exp_item.bytes) begin
        $error("out_bytes: expected %h, got %h", exp_item.bytes, got.bytes);
        errors++;
      end
      if (got.count != exp_item.count) begin
        $error("byte_count: expected %0d, got %0d", exp_item.count, got.count);
        errors++;
      end
      if (got.last != exp_item.last) begin
        $error("last_of_run: expected %0d, got %0d", exp_item.last, got.last);
        errors++;
      end
      if (got.done != exp_item.done) begin
        $error("image_done: expected %0d, got %0d", exp_item.done, got.done);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [brle8_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [brle8_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  brle8_pix_if pix_ch ();
  brle8_out_if code_ch ();

  rle8_scoreboard sb = new();
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned random_sent = 0;

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    code_ch.ready = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  bmp_rle8_encoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pixel_if   (pix_ch),
    .code_if    (code_ch)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    code_item_t got;
    if (rst_ni && code_ch.valid && code_ch.ready) begin
      got.bytes = code_ch.out_bytes;
      got.count = code_ch.byte_count;
      got.last = code_ch.last_of_run;
      got.done = code_ch.image_done;
      sb.check_code(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      code_ch.ready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 10);
      code_ch.ready <= 1'b0;
    end else begin
      code_ch.ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [brle8_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[brle8_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.configure(idx, val);
  endtask

  task automatic send_pixel(bit [brle8_pkg::PIX_W-1:0] px);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(posedge clk_i); while (!pix_ch.ready);
    sb.note_pixel(px);
  endtask

  task automatic set_image(int unsigned w, int unsigned h);
    pix_ch.valid <= 1'b0;
    wait_drained();
    write_reg(brle8_pkg::CFG_WIDTH, w);
    write_reg(brle8_pkg::CFG_HEIGHT, h);
  endtask

  function automatic bit [brle8_pkg::PIX_W-1:0] pick_pixel(pattern_e mode, int idx);
    bit [31:0] v;
    case (mode)
      PAT_ANY:  v = $urandom_range(0, 255);
      PAT_FEW:  v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
      PAT_FLAT: v = 32'h5A;
      default:  v = 32'(idx);
    endcase
    return v[7:0];
  endfunction

  task automatic run_image(int unsigned w, int unsigned h, int npix, pattern_e mode);
    set_image(w, h);
    for (int k = 0; k < npix; k++) send_pixel(pick_pixel(mode, k));
  endtask

  initial begin
    int unsigned w, h, n;
    bit [7:0]    seq [15];
    seq = '{8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd1, 8'd2, 8'd3,
            8'd4, 8'd5, 8'd9, 8'd9, 8'd4, 8'd4, 8'd4};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_image(1, 2);
    send_pixel(8'h00); send_pixel(8'hFF);
    set_image(2, 1);
    send_pixel(8'hAA); send_pixel(8'h55);
    set_image(0, 0);
    send_pixel(8'h3C);
    set_image(5, 3);
    foreach (seq[k]) send_pixel(seq[k]);
    set_image(3, 1);
    send_pixel(8'h01); send_pixel(8'h02); send_pixel(8'h02);

    run_image(260, 1, 260, PAT_FLAT);
    run_image(260, 1, 260, PAT_COUNT);
    run_image(4096, 2, 30, PAT_ANY);
    run_image(5000, 1, 10, PAT_FEW);
    run_image(1, 65535, 5, PAT_ANY);

    while (random_sent < 100) begin
      if (random_sent > 70) idle_on = 1'b0;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
      h = $urandom_range(1, 3);
      n = w * h + $urandom_range(0, w);
      run_image(w, h, n, ($urandom_range(0, 1) == 0) ? PAT_ANY : PAT_FEW);
      random_sent += n;
    end
    pix_ch.valid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
